@@ sv/hbfe_pkg.sv @@
// Package for the harmonic bond force and energy block.
// Holds widths, saturation limits and the sequencer state type.
// No dependencies.
package hbfe_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int IDX_BITS   = 16;
	localparam int POS_BITS   = 32;
	localparam int DIFF_BITS  = 33;
	localparam int SUMSQ_BITS = 67;
	localparam int LEN_BITS   = 34;
	localparam int DELTA_BITS = 35;
	localparam int FORCE_BITS = 48;
	localparam int EN_BITS    = 48;
	localparam int TOT_BITS   = 63;
	// widest dividend: |delta| * |r| * k
	localparam int NUM_BITS   = 98;
	localparam int DEN_BITS   = LEN_BITS + FRAC_BITS;
	// energy is k * delta^2 scaled down by 2F+1 bits
	localparam int EN_SHIFT   = 2 * FRAC_BITS + 1;
	localparam int IN_BYTES   = 36;
	localparam int OUT_BYTES  = 36;

	localparam logic [FORCE_BITS-1:0] FORCE_MAX = {1'b0, {(FORCE_BITS-1){1'b1}}};
	localparam logic [FORCE_BITS-1:0] FORCE_MIN = {1'b1, {(FORCE_BITS-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_SQRT,
		ST_DELTA,
		ST_EN1,
		ST_EN2,
		ST_EN3,
		ST_ENSAT,
		ST_FMUL1,
		ST_FMUL2,
		ST_FMUL3,
		ST_FDIV,
		ST_FNEXT,
		ST_OUT
	} hbfe_state_t;

endpackage

@@ sv/harmonic_bond_force_energy.sv @@
// Harmonic bond force and energy: one bond in, one result word out.
// Uses hbfe_pkg for widths, limits and the sequencer state type.
//
// Usage:
//   s_axis carries one bond per word (indices, both positions, k, L0) and
//   s_axis_tlast marks the last bond of a set. m_axis returns one word per
//   bond: indices, the force on bead b, the bond energy, the running energy
//   sum and a zero-length flag in tuser; m_axis_tlast repeats the last mark.
// Datapath:
//   All products run on one shared 34x34 multiplier with a 98-bit adder:
//   squares, the restoring square root (one bit per cycle), delta, k *
//   delta^2 in three steps plus saturation, then per axis three multiply
//   steps, a restoring divider that retires one quotient bit per cycle and
//   a store. A zero-length bond skips the divisions.
//   s_axis_tready is high only in idle with no result pending, so a new
//   bond is not taken until the last one has been sent out.
// Reset:
//   arst_n clears the sequencer, the output valid and the energy sum.
// Stall:
//   A result is held in the output register until m_axis_tready; the next
//   bond is not taken until then.
module harmonic_bond_force_energy
	import hbfe_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// bead_a_index, bead_b_index, a_x, a_y, a_z, b_x, b_y, b_z, stiffness, rest_length
	input  logic [IN_BYTES*8-1:0]    s_axis_tdata,
	input  logic                     s_axis_tlast,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// out_bead_a, out_bead_b, force_x, force_y, force_z, bond_energy, energy_total, pad
	output logic [OUT_BYTES*8-1:0]   m_axis_tdata,
	output logic                     m_axis_tlast,
	// zero_length
	output logic                     m_axis_tuser
);

	hbfe_state_t state_q, state_d;

	logic [IDX_BITS-1:0]       ia_q, ib_q;
	logic [POS_BITS-1:0]       k_q, l0_q;
	logic                      last_q;
	logic signed [DIFF_BITS-1:0] r_q [3];
	logic [SUMSQ_BITS-1:0]     s_q;
	logic [LEN_BITS-1:0]       d_q;
	logic signed [DELTA_BITS-1:0] delta_q;
	logic [2*LEN_BITS-1:0]     prod_q;
	logic [NUM_BITS-1:0]       acc_q;
	logic [NUM_BITS-1:0]       rem_q;
	logic [NUM_BITS-1:0]       quo_q;
	logic [6:0]                cnt_q;
	logic [1:0]                ax_q;
	logic [FORCE_BITS-1:0]     f_q [3];
	logic [EN_BITS-1:0]        en_val_q;
	logic [TOT_BITS-1:0]       sum_q;
	logic [TOT_BITS-1:0]       tot_out_q;
	logic                      zl_q;
	logic                      ovld_q;

	// shared multiplier
	logic [LEN_BITS-1:0]       mul_a, mul_b;
	logic [2*LEN_BITS-1:0]     mul_p;
	assign mul_p = (2*LEN_BITS)'(mul_a) * (2*LEN_BITS)'(mul_b);

	logic [DIFF_BITS-1:0] rmag;
	logic [DELTA_BITS-1:0] dmag;
	logic [LEN_BITS-1:0] cand;
	logic [DEN_BITS-1:0] den;
	logic [NUM_BITS:0]   rem_sh;
	logic                rem_ge;
	logic                fneg;
	logic [NUM_BITS-1:0] mac_sum;
	logic [TOT_BITS:0]   tot_next;
	logic [TOT_BITS-1:0] tot_sat;

	always_comb begin
		rmag = r_q[ax_q][DIFF_BITS-1] ? DIFF_BITS'(-r_q[ax_q]) : r_q[ax_q];
		dmag = delta_q[DELTA_BITS-1] ? DELTA_BITS'(-delta_q) : delta_q;
		cand = d_q | (LEN_BITS'(1) << cnt_q[5:0]);
		den  = {d_q, {FRAC_BITS{1'b0}}};
		rem_sh = {rem_q, acc_q[NUM_BITS-1]};
		rem_ge = rem_sh >= (NUM_BITS+1)'(den);
		fneg = (delta_q != '0) && (r_q[ax_q] != '0)
			&& (delta_q[DELTA_BITS-1] == r_q[ax_q][DIFF_BITS-1]);
		// add the upper partial product k * hi, weighted by 2^34
		mac_sum = acc_q + (NUM_BITS'(mul_p) << LEN_BITS);
		tot_next = {1'b0, sum_q} + (TOT_BITS+1)'(en_val_q);
		tot_sat = tot_next[TOT_BITS] ? '1 : tot_next[TOT_BITS-1:0];
	end

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q) inside
			ST_SQ: begin
				mul_a = LEN_BITS'(rmag);
				mul_b = LEN_BITS'(rmag);
			end
			ST_SQRT: begin
				mul_a = cand;
				mul_b = cand;
			end
			ST_EN1: begin
				mul_a = LEN_BITS'(dmag);
				mul_b = LEN_BITS'(dmag);
			end
			ST_FMUL1: begin
				mul_a = LEN_BITS'(dmag);
				mul_b = LEN_BITS'(rmag);
			end
			ST_EN2, ST_FMUL2: begin
				mul_a = LEN_BITS'(k_q);
				mul_b = prod_q[LEN_BITS-1:0];
			end
			ST_EN3, ST_FMUL3: begin
				mul_a = LEN_BITS'(k_q);
				mul_b = prod_q[2*LEN_BITS-1:LEN_BITS];
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_axis_tvalid && s_axis_tready) state_d = ST_SQ;
			ST_SQ:    if (ax_q == 2'd2) state_d = ST_SQRT;
			ST_SQRT:  if (cnt_q == '0) state_d = ST_DELTA;
			ST_DELTA: state_d = ST_EN1;
			ST_EN1:   state_d = ST_EN2;
			ST_EN2:   state_d = ST_EN3;
			ST_EN3:   state_d = ST_ENSAT;
			ST_ENSAT: state_d = (d_q == '0) ? ST_OUT : ST_FMUL1;
			ST_FMUL1: state_d = ST_FMUL2;
			ST_FMUL2: state_d = ST_FMUL3;
			ST_FMUL3: state_d = ST_FDIV;
			ST_FDIV:  if (cnt_q == '0) state_d = ST_FNEXT;
			ST_FNEXT: state_d = (ax_q == 2'd2) ? ST_OUT : ST_FMUL1;
			ST_OUT:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control counters, output valid and energy sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ax_q   <= '0;
			ovld_q <= 1'b0;
			sum_q  <= '0;
		end else begin
			if (state_q == ST_OUT) begin
				ovld_q <= 1'b1;
			end else if (m_axis_tready) begin
				ovld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE:  ax_q <= '0;
				ST_SQ: begin
					ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
					cnt_q <= 7'(LEN_BITS-1);
				end
				ST_SQRT:  if (cnt_q != '0) cnt_q <= cnt_q - 7'd1;
				ST_FMUL3: cnt_q <= 7'(NUM_BITS-1);
				ST_FDIV:  if (cnt_q != '0) cnt_q <= cnt_q - 7'd1;
				ST_FNEXT: ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
				ST_OUT:   sum_q <= last_q ? '0 : tot_sat;
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
				ia_q   <= s_axis_tdata[15:0];
				ib_q   <= s_axis_tdata[31:16];
				k_q    <= s_axis_tdata[255:224];
				l0_q   <= s_axis_tdata[287:256];
				last_q <= s_axis_tlast;
				r_q[0] <= DIFF_BITS'($signed(s_axis_tdata[159:128]))
					- DIFF_BITS'($signed(s_axis_tdata[63:32]));
				r_q[1] <= DIFF_BITS'($signed(s_axis_tdata[191:160]))
					- DIFF_BITS'($signed(s_axis_tdata[95:64]));
				r_q[2] <= DIFF_BITS'($signed(s_axis_tdata[223:192]))
					- DIFF_BITS'($signed(s_axis_tdata[127:96]));
				s_q <= '0;
				d_q <= '0;
			end
			ST_SQ: s_q <= s_q + SUMSQ_BITS'(mul_p);
			ST_SQRT: if (mul_p <= {1'b0, s_q}) d_q <= cand;
			ST_DELTA: begin
				delta_q <= DELTA_BITS'(d_q) - DELTA_BITS'(l0_q);
				zl_q <= (d_q == '0);
			end
			ST_EN1: prod_q <= mul_p;
			ST_EN2: acc_q <= NUM_BITS'(mul_p);
			ST_EN3: acc_q <= mac_sum;
			// energy = k * delta^2 >> (2F+1), saturated
			ST_ENSAT: begin
				en_val_q <= (acc_q[NUM_BITS-1:EN_SHIFT+EN_BITS] != '0) ? '1
					: acc_q[EN_SHIFT+EN_BITS-1:EN_SHIFT];
				f_q[0] <= '0;
				f_q[1] <= '0;
				f_q[2] <= '0;
			end
			ST_FMUL1: prod_q <= mul_p;
			ST_FMUL2: acc_q <= NUM_BITS'(mul_p);
			ST_FMUL3: begin
				acc_q <= mac_sum;
				rem_q <= '0;
				quo_q <= '0;
			end
			ST_FDIV: begin
				rem_q <= rem_ge ? NUM_BITS'(rem_sh - (NUM_BITS+1)'(den))
					: NUM_BITS'(rem_sh);
				quo_q <= {quo_q[NUM_BITS-2:0], rem_ge};
				acc_q <= {acc_q[NUM_BITS-2:0], 1'b0};
			end
			ST_FNEXT: begin
				if (fneg) begin
					f_q[ax_q] <= (quo_q > NUM_BITS'(FORCE_MIN)) ? FORCE_MIN
						: FORCE_BITS'(-quo_q);
				end else begin
					f_q[ax_q] <= (quo_q > NUM_BITS'(FORCE_MAX)) ? FORCE_MAX
						: quo_q[FORCE_BITS-1:0];
				end
			end
			ST_OUT: tot_out_q <= tot_sat;
			default: ;
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE) && !ovld_q;
	assign m_axis_tvalid = ovld_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tuser  = zl_q;
	assign m_axis_tdata  = {1'b0, tot_out_q, en_val_q, f_q[2], f_q[1], f_q[0], ib_q, ia_q};

`ifndef ASSERT_OFF
	a_out_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> s_axis_tready == 1'b0)
		else $error("input taken while result pending");
	a_zero_force: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata[175:32] == '0)
		else $error("nonzero force on zero-length bond");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result dropped");
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");
`endif

endmodule
